>>> rtl/prdg_pkg.sv
// ----------------------------------------------------------------------------
// prdg_pkg: shared types and constants for the primary ray direction generator
// Pixel and ray payload structs, configuration register indexes, reset values.
// ----------------------------------------------------------------------------
package prdg_pkg;

  localparam int MAX_WIDTH_DEFAULT = 4096;
  localparam int CFG_DATA_W        = 48;

  typedef enum logic [2:0] {
    CFG_IMAGE_WIDTH = 3'd0,
    CFG_INV_WIDTH   = 3'd1,
    CFG_INV_HEIGHT  = 3'd2,
    CFG_FOV_SCALE   = 3'd3,
    CFG_AXIS_RIGHT  = 3'd4,
    CFG_AXIS_UP     = 3'd5,
    CFG_AXIS_BACK   = 3'd6
  } cfg_index_t;

  localparam logic [12:0] IMAGE_WIDTH_RST = 13'd640;
  localparam logic [24:0] INV_WIDTH_RST   = 25'd26214;
  localparam logic [24:0] INV_HEIGHT_RST  = 25'd34953;
  localparam logic [15:0] FOV_SCALE_RST   = 16'd4096;
  localparam logic [47:0] AXIS_RIGHT_RST  = 48'd16384;
  localparam logic [47:0] AXIS_UP_RST     = 48'd1073741824;
  localparam logic [47:0] AXIS_BACK_RST   = 48'd70368744177664;

  typedef struct packed {
    logic [11:0] pixel_y;
    logic [11:0] pixel_x;
  } pixel_t;

  typedef struct packed {
    logic        [23:0] buffer_index;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
  } ray_t;

endpackage

>>> rtl/primary_ray_direction_generator.sv
// ----------------------------------------------------------------------------
// primary_ray_direction_generator: pinhole camera primary ray directions
// One pixel per cycle is taken in while no finished result is stalled at the output.
// The 31-stage square root and the 16-stage divider set the depth.
// The whole pipeline holds while a finished result is stalled at the output.
// Synchronous reset clears all valid bits and loads default camera registers.
// ----------------------------------------------------------------------------
module primary_ray_direction_generator #(
  parameter int MAX_WIDTH = prdg_pkg::MAX_WIDTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [2:0]                      cfg_index,
  input  logic [prdg_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  prdg_pkg::pixel_t                in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output prdg_pkg::ray_t                  out_data
);
  import prdg_pkg::*;

  localparam int LAT = 60;
  localparam int SQ_N = 31;
  localparam int DV_N = 16;

  typedef struct packed {
    logic [23:0]      idx;
    logic [2:0]       neg;
    logic             zero;
    logic [2:0][29:0] mag;
  } sq_side_t;

  typedef struct packed {
    logic [23:0] idx;
    logic [2:0]  neg;
    logic        zero;
  } dv_side_t;

  // Configuration registers
  logic [12:0] image_width;
  logic [24:0] inv_width, inv_height;
  logic [15:0] fov_scale;
  logic [47:0] axis_right, axis_up, axis_back;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= IMAGE_WIDTH_RST;
      inv_width   <= INV_WIDTH_RST;
      inv_height  <= INV_HEIGHT_RST;
      fov_scale   <= FOV_SCALE_RST;
      axis_right  <= AXIS_RIGHT_RST;
      axis_up     <= AXIS_UP_RST;
      axis_back   <= AXIS_BACK_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH: image_width <= cfg_data[12:0];
        CFG_INV_WIDTH:   inv_width   <= cfg_data[24:0];
        CFG_INV_HEIGHT:  inv_height  <= cfg_data[24:0];
        CFG_FOV_SCALE:   fov_scale   <= cfg_data[15:0];
        CFG_AXIS_RIGHT:  axis_right  <= cfg_data;
        CFG_AXIS_UP:     axis_up     <= cfg_data;
        CFG_AXIS_BACK:   axis_back   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline advance and valid bits
  logic           adv;
  logic [LAT-1:0] vld;

  assign adv       = !(vld[LAT-1] && out_stall);
  assign in_stall  = !adv;
  assign out_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  function automatic logic [5:0] lead_pos(input logic [55:0] v);
    logic [5:0] pos;
    pos = '0;
    for (int i = 0; i < 56; i++) begin
      if (v[i]) pos = 6'(i);
    end
    return pos;
  endfunction

  // Axis components as signed Q1.14
  logic signed [15:0] ax_r [3];
  logic signed [15:0] ax_u [3];
  logic signed [15:0] ax_b [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ax_r[k] = axis_right[16*k +: 16];
      ax_u[k] = axis_up[16*k +: 16];
      ax_b[k] = axis_back[16*k +: 16];
    end
  end

  // Stage 1: (2c+1)*inv - 1, and the buffer index
  logic        [37:0] prod_x, prod_y;
  logic        [12:0] width_sat;
  logic        [24:0] row_off;
  logic signed [38:0] s1_tx, s1_ty;
  logic        [23:0] idx_d [11];

  assign prod_x    = 38'({in_data.pixel_x, 1'b1}) * 38'(inv_width);
  assign prod_y    = 38'({in_data.pixel_y, 1'b1}) * 38'(inv_height);
  assign width_sat = (32'(image_width) > MAX_WIDTH) ? 13'(MAX_WIDTH) : image_width;
  assign row_off   = 25'(in_data.pixel_y) * 25'(width_sat);

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_tx    <= $signed({1'b0, prod_x}) - 39'sd16777216;
      s1_ty    <= $signed({1'b0, prod_y}) - 39'sd16777216;
      idx_d[0] <= 24'(row_off + 25'(in_data.pixel_x));
      for (int i = 1; i < 11; i++) idx_d[i] <= idx_d[i-1];
    end
  end

  // Stages 2 to 5: field-of-view scale, rounding, rotation into world space
  logic signed [55:0] fov_s;
  logic signed [55:0] s2_px, s2_py;
  logic signed [39:0] s3_px, s3_py;
  logic signed [55:0] s4_pr [3];
  logic signed [55:0] s4_pu [3];
  logic signed [57:0] s5_w  [3];

  assign fov_s = $signed({40'd0, fov_scale});

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_px <= 56'(s1_tx) * fov_s;
      s2_py <= 56'(s1_ty) * fov_s;
      s3_px <= 40'((s2_px + 56'sd32768) >>> 16);
      s3_py <= 40'((s2_py + 56'sd32768) >>> 16);
      for (int k = 0; k < 3; k++) begin
        s4_pr[k] <= 56'(s3_px) * 56'(ax_r[k]);
        s4_pu[k] <= 56'(s3_py) * 56'(ax_u[k]);
        s5_w[k]  <= 58'(s4_pr[k]) + 58'(s4_pu[k]) - (58'(ax_b[k]) <<< 20);
      end
    end
  end

  // Stages 6 to 11: magnitudes, common normalizing shift, sum of squares
  logic [55:0] s6_mag [3];
  logic [55:0] s7_mag [3];
  logic [55:0] s8_mag [3];
  logic [55:0] s7_big;
  logic [5:0]  s8_msb;
  logic [29:0] s9_mag  [3];
  logic [29:0] s10_mag [3];
  logic [29:0] s11_mag [3];
  logic [59:0] s10_sq  [3];
  logic [61:0] s11_sum;
  logic [2:0]  neg_d  [6];
  logic        zero_d [4];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        neg_d[0][k] <= s5_w[k][57];
        s6_mag[k]   <= 56'(s5_w[k][57] ? -s5_w[k] : s5_w[k]);
        s7_mag[k]   <= s6_mag[k];
        s8_mag[k]   <= s7_mag[k];
        if (s8_msb > 6'd29) begin
          s9_mag[k] <= 30'(s8_mag[k] >> (s8_msb - 6'd29));
        end else begin
          s9_mag[k] <= 30'(s8_mag[k] << (6'd29 - s8_msb));
        end
        s10_mag[k] <= s9_mag[k];
        s10_sq[k]  <= 60'(s9_mag[k]) * 60'(s9_mag[k]);
        s11_mag[k] <= s10_mag[k];
      end
      for (int i = 1; i < 6; i++) neg_d[i] <= neg_d[i-1];
      if (s6_mag[0] >= s6_mag[1] && s6_mag[0] >= s6_mag[2]) begin
        s7_big <= s6_mag[0];
      end else if (s6_mag[1] >= s6_mag[2]) begin
        s7_big <= s6_mag[1];
      end else begin
        s7_big <= s6_mag[2];
      end
      s8_msb    <= lead_pos(s7_big);
      zero_d[0] <= (s7_big == '0);
      for (int i = 1; i < 4; i++) zero_d[i] <= zero_d[i-1];
      s11_sum <= 62'(s10_sq[0]) + 62'(s10_sq[1]) + 62'(s10_sq[2]);
    end
  end

  // Square root, one result bit per stage
  logic     [61:0] sq_s  [SQ_N+1];
  logic     [62:0] sq_r  [SQ_N+1];
  sq_side_t        sq_sd [SQ_N+1];

  assign sq_s[0]         = s11_sum;
  assign sq_r[0]         = '0;
  assign sq_sd[0].idx    = idx_d[10];
  assign sq_sd[0].neg    = neg_d[5];
  assign sq_sd[0].zero   = zero_d[3];
  assign sq_sd[0].mag[0] = s11_mag[0];
  assign sq_sd[0].mag[1] = s11_mag[1];
  assign sq_sd[0].mag[2] = s11_mag[2];

  for (genvar i = 0; i < SQ_N; i++) begin : g_sqrt
    localparam int K = SQ_N - 1 - i;
    logic [62:0] trial;
    assign trial = sq_r[i] + (63'(1) << (2 * K));
    always_ff @(posedge clk) begin
      if (adv) begin
        sq_sd[i+1] <= sq_sd[i];
        if (63'(sq_s[i]) >= trial) begin
          sq_s[i+1] <= 62'(63'(sq_s[i]) - trial);
          sq_r[i+1] <= (sq_r[i] >> 1) + (63'(1) << (2 * K));
        end else begin
          sq_s[i+1] <= sq_s[i];
          sq_r[i+1] <= sq_r[i] >> 1;
        end
      end
    end
  end

  // Division (m*16384 + r/2) / r, one quotient bit per stage
  logic     [45:0] dv_rem [DV_N+1][3];
  logic     [15:0] dv_q   [DV_N+1][3];
  logic     [30:0] dv_r   [DV_N+1];
  dv_side_t        dv_sd  [DV_N+1];
  logic     [30:0] root;

  assign root = 31'(sq_r[SQ_N]);

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_r[0]       <= root;
      dv_sd[0].idx  <= sq_sd[SQ_N].idx;
      dv_sd[0].neg  <= sq_sd[SQ_N].neg;
      dv_sd[0].zero <= sq_sd[SQ_N].zero;
      for (int k = 0; k < 3; k++) begin
        dv_rem[0][k] <= (46'(sq_sd[SQ_N].mag[k]) << 14) + 46'(root >> 1);
        dv_q[0][k]   <= '0;
      end
    end
  end

  for (genvar i = 0; i < DV_N; i++) begin : g_div
    localparam int J = DV_N - 1 - i;
    logic [45:0] dsh;
    assign dsh = 46'(dv_r[i]) << J;
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_r[i+1]  <= dv_r[i];
        dv_sd[i+1] <= dv_sd[i];
        for (int k = 0; k < 3; k++) begin
          if (dv_rem[i][k] >= dsh) begin
            dv_rem[i+1][k] <= dv_rem[i][k] - dsh;
            dv_q[i+1][k]   <= dv_q[i][k] | (16'(1) << J);
          end else begin
            dv_rem[i+1][k] <= dv_rem[i][k];
            dv_q[i+1][k]   <= dv_q[i][k];
          end
        end
      end
    end
  end

  // Output register: clamp to one, apply sign, zero vector gives zero
  logic [15:0] dir_mag [3];
  logic [15:0] dir_val [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dir_mag[k] = (dv_q[DV_N][k] > 16'd16384) ? 16'd16384 : dv_q[DV_N][k];
      if (dv_sd[DV_N].zero) begin
        dir_val[k] = '0;
      end else if (dv_sd[DV_N].neg[k]) begin
        dir_val[k] = 16'(-dir_mag[k]);
      end else begin
        dir_val[k] = dir_mag[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data.buffer_index <= dv_sd[DV_N].idx;
      out_data.dir_x        <= dir_val[0];
      out_data.dir_y        <= dir_val[1];
      out_data.dir_z        <= dir_val[2];
    end
  end

endmodule

>>> tb/sv/primary_ray_direction_generator_tb.sv
// ----------------------------------------------------------------------------
// primary_ray_direction_generator_tb: self-checking bench for ray generation
// A directed pixel table, then random pixels under random camera setups, with
// random gaps on both sides and one long output hold. An internal camera model
// predicts the rays of untyped rows, and results are checked in order, field by field.
// ----------------------------------------------------------------------------
module primary_ray_direction_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import prdg_pkg::*;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [2:0]            cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  pixel_t                in_data;
  logic                  out_valid;
  logic                  out_stall;
  ray_t                  out_data;

  primary_ray_direction_generator u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data)
  );

  typedef struct {
    pixel_t pix;
    bit     typed;
    ray_t   ray;
  } pixel_row_t;

  // Camera registers as the block should hold them.
  logic [12:0] cam_width;
  logic [24:0] cam_inv_w;
  logic [24:0] cam_inv_h;
  logic [15:0] cam_fov;
  logic [47:0] cam_right;
  logic [47:0] cam_up;
  logic [47:0] cam_back;

  ray_t       ray_q[$];
  pixel_row_t rows[$];
  bit         cur_typed;
  ray_t       cur_ray;
  bit         gaps_on;
  bit         rx_gaps_on;
  int         pixels_sent;
  int         rays_checked;
  int         mismatches;
  int         setups;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic void load_camera(logic [2:0] idx, logic [47:0] val);
    case (idx)
      CFG_IMAGE_WIDTH: cam_width = val[12:0];
      CFG_INV_WIDTH:   cam_inv_w = val[24:0];
      CFG_INV_HEIGHT:  cam_inv_h = val[24:0];
      CFG_FOV_SCALE:   cam_fov   = val[15:0];
      CFG_AXIS_RIGHT:  cam_right = val;
      CFG_AXIS_UP:     cam_up    = val;
      CFG_AXIS_BACK:   cam_back  = val;
      default: ;
    endcase
  endfunction

  // Screen-plane coordinate in Q.20, rounded half up.
  function automatic longint plane_coord(logic [11:0] c, logic [24:0] inv);
    longint cc;
    longint iv;
    longint fv;
    longint t;
    cc = c;
    iv = inv;
    fv = cam_fov;
    t = (2 * cc + 1) * iv - (64'sd1 <<< 24);
    return (t * fv + 32768) >>> 16;
  endfunction

  function automatic longint axis_comp(logic [47:0] a, int k);
    logic signed [15:0] f;
    f = a[16*k +: 16];
    return f;
  endfunction

  function automatic logic [63:0] root_floor(logic [63:0] s);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s = s - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic ray_t predict_ray(pixel_t p);
    ray_t        o;
    longint      px;
    longint      py;
    longint      v;
    logic [63:0] mag[3];
    bit          neg[3];
    logic [63:0] big;
    logic [63:0] s;
    logic [63:0] r;
    logic [63:0] d;
    logic [15:0] dv[3];
    logic [12:0] w;
    int          msb;
    w = (cam_width > 13'd4096) ? 13'd4096 : cam_width;
    o.buffer_index = 24'(48'(p.pixel_y) * 48'(w) + 48'(p.pixel_x));
    px = plane_coord(p.pixel_x, cam_inv_w);
    py = plane_coord(p.pixel_y, cam_inv_h);
    big = 0;
    for (int k = 0; k < 3; k++) begin
      v = px * axis_comp(cam_right, k) + py * axis_comp(cam_up, k)
          - axis_comp(cam_back, k) * (64'sd1 <<< 20);
      neg[k] = v < 0;
      mag[k] = neg[k] ? 64'(-v) : 64'(v);
      if (mag[k] > big) big = mag[k];
    end
    if (big == 0) begin
      dv = '{16'd0, 16'd0, 16'd0};
    end else begin
      msb = 63;
      while (big[msb] == 1'b0) msb--;
      s = 0;
      for (int k = 0; k < 3; k++) begin
        if (msb > 29) mag[k] = mag[k] >> (msb - 29);
        else mag[k] = mag[k] << (29 - msb);
        s = s + mag[k] * mag[k];
      end
      r = root_floor(s);
      for (int k = 0; k < 3; k++) begin
        d = (mag[k] * 16384 + (r >> 1)) / r;
        if (d > 16384) d = 16384;
        dv[k] = neg[k] ? 16'(-d) : 16'(d);
      end
    end
    o.dir_x = dv[0];
    o.dir_y = dv[1];
    o.dir_z = dv[2];
    return o;
  endfunction

  task automatic write_camera(logic [2:0] idx, logic [47:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    load_camera(idx, val);
  endtask

  task automatic setup_camera(logic [12:0] w, logic [24:0] iw, logic [24:0] ih,
                              logic [15:0] fov, logic [47:0] rt, logic [47:0] up,
                              logic [47:0] bk);
    write_camera(CFG_IMAGE_WIDTH, 48'(w));
    write_camera(CFG_INV_WIDTH, 48'(iw));
    write_camera(CFG_INV_HEIGHT, 48'(ih));
    write_camera(CFG_FOV_SCALE, 48'(fov));
    write_camera(CFG_AXIS_RIGHT, rt);
    write_camera(CFG_AXIS_UP, up);
    write_camera(CFG_AXIS_BACK, bk);
    cfg_we <= 1'b0;
    setups++;
  endtask

  // Settle until every ray is back and the pipeline has emptied.
  task automatic drain;
    while (ray_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic send_pixel(pixel_t p, bit typed, ray_t r);
    int gap;
    gap = 0;
    if (gaps_on) begin
      gap = $urandom_range(0, 99);
      gap = (gap < 70) ? 0 : (gap < 96) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cur_typed <= typed;
    cur_ray <= r;
    in_valid <= 1'b1;
    in_data <= p;
    do @(posedge clk); while (in_stall);
    pixels_sent++;
  endtask

  function automatic logic [47:0] rand_axis();
    logic [47:0] a;
    a = 48'({$urandom(), $urandom()});
    for (int k = 0; k < 3; k++) begin
      case ($urandom_range(0, 5))
        0: a[16*k +: 16] = 16'h8000;
        1: a[16*k +: 16] = 16'h7fff;
        2: a[16*k +: 16] = 16'd0;
        3: a[16*k +: 16] = 16'(signed'(16'($urandom_range(0, 32768))) - 16'sd16384);
        default: ;
      endcase
    end
    return a;
  endfunction

  // Acceptance side: predict at the transfer, unless the row is typed.
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      ray_q.push_back(cur_typed ? cur_ray : predict_ray(in_data));
    end
  end

  always @(posedge clk) begin
    ray_t e;
    if (!rst && out_valid && !out_stall) begin
      if (ray_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected ray %p", out_data);
      end else begin
        e = ray_q.pop_front();
        rays_checked++;
        if (e.buffer_index !== out_data.buffer_index || e.dir_x !== out_data.dir_x ||
            e.dir_y !== out_data.dir_y || e.dir_z !== out_data.dir_z) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Ray mismatch: expected idx=%0d dir=(%0d,%0d,%0d) got idx=%0d dir=(%0d,%0d,%0d)",
                     e.buffer_index, e.dir_x, e.dir_y, e.dir_z, out_data.buffer_index,
                     out_data.dir_x, out_data.dir_y, out_data.dir_z);
          end
        end
      end
    end
  end

  // Receiver: random stalls in bursts, and one long hold while pixels keep coming.
  initial begin
    int hold;
    bit held;
    held = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!held && pixels_sent >= 400) begin
        held = 1;
        out_stall <= 1'b1;
        hold = 0;
        while (hold < 300) begin
          @(posedge clk);
          hold++;
        end
        out_stall <= 1'b0;
      end else if (rx_gaps_on && $urandom_range(0, 99) < 3) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(8, 30)) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= rx_gaps_on && ($urandom_range(0, 99) < 25);
      end
    end
  end

  initial begin
    #5ms;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    pixel_t p;
    ray_t   z;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_data = '0;
    cur_typed = 0;
    cur_ray = '0;
    gaps_on = 0;
    rx_gaps_on = 0;
    pixels_sent = 0;
    rays_checked = 0;
    mismatches = 0;
    setups = 0;
    load_camera(CFG_IMAGE_WIDTH, 48'(IMAGE_WIDTH_RST));
    load_camera(CFG_INV_WIDTH, 48'(INV_WIDTH_RST));
    load_camera(CFG_INV_HEIGHT, 48'(INV_HEIGHT_RST));
    load_camera(CFG_FOV_SCALE, 48'(FOV_SCALE_RST));
    load_camera(CFG_AXIS_RIGHT, AXIS_RIGHT_RST);
    load_camera(CFG_AXIS_UP, AXIS_UP_RST);
    load_camera(CFG_AXIS_BACK, AXIS_BACK_RST);
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset camera: corners, center, and a column past the width.
    z = '0;
    rows = '{
      '{'{12'd0, 12'd0}, 0, z}, '{'{12'd4095, 12'd4095}, 0, z},
      '{'{12'd479, 12'd639}, 0, z}, '{'{12'd240, 12'd320}, 0, z},
      '{'{12'd0, 12'd4095}, 0, z}, '{'{12'd4095, 12'd0}, 0, z},
      '{'{12'd5, 12'd1000}, 0, z}, '{'{12'd2730, 12'd1365}, 0, z}
    };
    foreach (rows[i]) send_pixel(rows[i].pix, 0, z);
    in_valid <= 1'b0;
    drain();

    // No field of view and no back axis: every world vector is zero.
    write_camera(3'd7, 48'hffff_ffff_ffff);
    setup_camera(13'd640, 25'd26214, 25'd34953, 16'd0, AXIS_RIGHT_RST, AXIS_UP_RST, 48'd0);
    rows = '{
      '{'{12'd2, 12'd3}, 1, '{24'd1283, 16'sd0, 16'sd0, 16'sd0}},
      '{'{12'd4095, 12'd4095}, 1, '{24'd2624895, 16'sd0, 16'sd0, 16'sd0}}
    };
    foreach (rows[i]) send_pixel(rows[i].pix, rows[i].typed, rows[i].ray);
    in_valid <= 1'b0;
    drain();

    // Zero width gives the column alone; an oversized width saturates.
    setup_camera(13'd0, 25'd4096, 25'd16777216, 16'd0, 48'd0, 48'd0, 48'd0);
    send_pixel('{12'd9, 12'd7}, 1, '{24'd7, 16'sd0, 16'sd0, 16'sd0});
    in_valid <= 1'b0;
    drain();
    setup_camera(13'd8191, 25'h1ffffff, 25'd0, 16'hffff, 48'h8000_8000_8000,
                 48'h7fff_7fff_7fff, 48'h8000_0000_7fff);
    send_pixel('{12'd1, 12'd5}, 0, z);
    send_pixel('{12'd4095, 12'd4095}, 0, z);
    send_pixel('{12'd0, 12'd0}, 0, z);
    in_valid <= 1'b0;
    drain();

    // Random cameras, each followed by a burst of pixels.
    gaps_on = 1;
    rx_gaps_on = 1;
    for (int ph = 0; ph < 6; ph++) begin
      logic [12:0] w;
      int          n;
      case (ph)
        0: w = 13'd4096;
        1: w = 13'd1;
        default: w = 13'($urandom_range(1, 4096));
      endcase
      setup_camera(w,
                   ($urandom_range(0, 7) == 0) ? 25'($urandom()) : 25'($urandom_range(4096, 16777216)),
                   ($urandom_range(0, 7) == 0) ? 25'($urandom()) : 25'($urandom_range(4096, 16777216)),
                   (ph == 1) ? 16'hffff : 16'($urandom_range(0, 65535)),
                   rand_axis(), rand_axis(), rand_axis());
      n = (ph == 0) ? 600 : 90;
      for (int i = 0; i < n; i++) begin
        p.pixel_x = ($urandom_range(0, 9) == 0) ? 12'($urandom()) :
                    12'($urandom_range(0, (w > 13'd4096 ? 4096 : w) - 1));
        p.pixel_y = 12'($urandom());
        if (ph == 1 && i % 30 == 0) gaps_on = !gaps_on;
        send_pixel(p, 0, z);
      end
      gaps_on = 1;
      in_valid <= 1'b0;
      drain();
    end

    $display("Sent %0d pixels through %0d camera setups; %0d rays checked.",
             pixels_sent, setups, rays_checked);
    $display("Covered zero vectors, width saturation and a long output hold.");
    if (mismatches == 0 && ray_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
